// ----- rtl/core/frame_animation_timer_macros.svh -----
// ----------------------------------------------------------------------------
// Frame animation timer assertion macros
// Clocked, reset-qualified assertion helpers for the timer core.
// ----------------------------------------------------------------------------
`ifndef FRAME_ANIMATION_TIMER_MACROS_SVH
`define FRAME_ANIMATION_TIMER_MACROS_SVH

// generic form: explicit clock and active-low reset
`define FAT_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// core form: clk_i / rst_ni
`define FAT_ASSERT(label, prop, msg) \
  `FAT_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/core/fat_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame animation timer package
// Widths, codes and sequencer states shared by the timer core.
// ----------------------------------------------------------------------------
package fat_pkg;

  localparam int unsigned MaxFrames = 16;
  localparam int unsigned FrameW    = 4;
  localparam int unsigned CountW    = 5;
  localparam int unsigned DurW      = 16;
  localparam int unsigned TotalW    = DurW + FrameW;
  localparam int unsigned ElapsedW  = 32;
  localparam int unsigned BitCntW   = 5;
  localparam int unsigned IncW      = 10;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 10;
  localparam int unsigned FuncW     = 2;
  localparam int unsigned InW       = 24;
  localparam int unsigned OutW      = 40;

  localparam logic [IncW-1:0]   IncRst   = 10'd16;
  localparam logic [CountW-1:0] CountRst = 5'd1;

  typedef enum logic [FuncW-1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_LOAD    = 2'd1,
    FUNC_RESTART = 2'd2,
    FUNC_STOP    = 2'd3
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TICK_INC = 2'd0,
    CFG_REVERSE  = 2'd1,
    CFG_LOOPING  = 2'd2,
    CFG_FRAMES   = 2'd3
  } cfg_reg_e;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SUM  = 7'b0000010,
    S_UPD  = 7'b0000100,
    S_MOD  = 7'b0001000,
    S_PICK = 7'b0010000,
    S_WALK = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

endpackage

// ----- rtl/core/frame_animation_timer.sv -----
// ----------------------------------------------------------------------------
// Frame animation timer
// Per-frame duration table, elapsed counter and frame selection.
// ----------------------------------------------------------------------------
// One item at a time. An item passes through accept, a sum of the table
// through one adder over the n frames in use, update, the bit-serial
// remainder unit, select, a walk over the table and the output step.
// With a zero total the remainder, select and walk are skipped. The
// result sits in an output register, so the next item is accepted while it
// waits.
module frame_animation_timer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // [3:0] entry_index, [19:4] entry_duration, [20] arm_notice
  input  logic [fat_pkg::InW-1:0]     s_axis_tdata_i,
  // [1:0] func
  input  logic [fat_pkg::FuncW-1:0]   s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // [3:0] current_frame, [4] finished, [5] done_pulse, [37:6] elapsed_now
  output logic [fat_pkg::OutW-1:0]    m_axis_tdata_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [fat_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [fat_pkg::CfgDataW-1:0] cfg_data_i
);

  import fat_pkg::*;

  state_e                 state_q;
  logic [IncW-1:0]        tick_inc_q;
  logic                   reverse_q;
  logic                   looping_q;
  logic [CountW-1:0]      frame_cnt_q;

  logic [DurW-1:0]        table_q [MaxFrames];
  logic [ElapsedW-1:0]    elapsed_q;
  logic                   running_q;
  logic                   armed_q;

  func_e                  func_q;
  logic                   arm_q;
  logic                   done_q;
  logic                   reduce_q;
  logic [CountW-1:0]      n_q;
  logic [FrameW-1:0]      idx_q;
  logic [TotalW-1:0]      total_q;
  logic [TotalW-1:0]      rem_q;
  logic [BitCntW-1:0]     bit_q;
  logic [FrameW-1:0]      frm_q;

  logic                   m_valid_q;
  logic [OutW-1:0]        m_data_q;

  logic                   in_xfer;
  logic [CountW-1:0]      n_used;
  logic [ElapsedW-1:0]    tick_sum;
  logic                   tick_hit;
  logic [TotalW:0]        mod_trial;
  logic                   mod_ge;
  logic [TotalW-1:0]      mod_rem;
  logic [TotalW-1:0]      walk_d;
  logic                   walk_ge;
  logic                   fwd_ok;
  logic                   rev_ok;
  logic                   fin;
  logic                   total_zero;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i & s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  always_comb begin
    if (frame_cnt_q == '0) begin
      n_used = CountW'(1);
    end else if (frame_cnt_q > CountW'(MaxFrames)) begin
      n_used = CountW'(MaxFrames);
    end else begin
      n_used = frame_cnt_q;
    end
  end

  assign total_zero = (total_q == '0);
  assign tick_sum   = elapsed_q + ElapsedW'(tick_inc_q);
  assign tick_hit   = armed_q & (tick_sum >= ElapsedW'(total_q));

  // restoring remainder, one dividend bit per cycle
  assign mod_trial = {rem_q, elapsed_q[bit_q]};
  assign mod_ge    = (mod_trial >= {1'b0, total_q});
  assign mod_rem   = mod_ge ? TotalW'(mod_trial - {1'b0, total_q}) : mod_trial[TotalW-1:0];

  assign walk_d  = TotalW'(table_q[frm_q]);
  assign walk_ge = (rem_q >= walk_d);
  assign fwd_ok  = walk_ge & ((CountW'(frm_q) + CountW'(1)) < n_q);
  assign rev_ok  = walk_ge & (frm_q != '0);
  assign fin     = (elapsed_q >= ElapsedW'(total_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tick_inc_q  <= IncRst;
      reverse_q   <= 1'b0;
      looping_q   <= 1'b1;
      frame_cnt_q <= CountRst;
      for (int i = 0; i < MaxFrames; i++) begin
        table_q[i] <= '0;
      end
      elapsed_q   <= '0;
      running_q   <= 1'b0;
      armed_q     <= 1'b0;
      func_q      <= FUNC_TICK;
      arm_q       <= 1'b0;
      done_q      <= 1'b0;
      reduce_q    <= 1'b0;
      n_q         <= CountRst;
      idx_q       <= '0;
      total_q     <= '0;
      rem_q       <= '0;
      bit_q       <= '0;
      frm_q       <= '0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_TICK_INC: tick_inc_q  <= cfg_data_i[IncW-1:0];
          CFG_REVERSE:  reverse_q   <= cfg_data_i[0];
          CFG_LOOPING:  looping_q   <= cfg_data_i[0];
          CFG_FRAMES:   frame_cnt_q <= cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end

      if (m_valid_q && m_axis_tready_i && (state_q != S_OUT)) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            func_q   <= func_e'(s_axis_tuser_i);
            arm_q    <= s_axis_tdata_i[20];
            done_q   <= 1'b0;
            reduce_q <= 1'b0;
            n_q      <= n_used;
            idx_q    <= '0;
            total_q  <= '0;
            if (func_e'(s_axis_tuser_i) == FUNC_LOAD) begin
              table_q[s_axis_tdata_i[FrameW-1:0]] <= s_axis_tdata_i[FrameW +: DurW];
            end
            state_q  <= S_SUM;
          end
        end
        S_SUM: begin
          total_q <= total_q + TotalW'(table_q[idx_q]);
          idx_q   <= idx_q + FrameW'(1);
          if (CountW'(idx_q) == (n_q - CountW'(1))) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          case (func_q)
            FUNC_TICK: begin
              if (running_q) begin
                elapsed_q <= (tick_hit && total_zero) ? '0 : tick_sum;
                if (tick_hit) begin
                  armed_q  <= 1'b0;
                  done_q   <= 1'b1;
                  reduce_q <= 1'b1;
                end
              end
            end
            FUNC_RESTART: begin
              done_q    <= armed_q;
              armed_q   <= arm_q;
              elapsed_q <= '0;
              running_q <= 1'b1;
            end
            FUNC_STOP: begin
              running_q <= 1'b0;
            end
            default: ;
          endcase
          rem_q <= '0;
          bit_q <= BitCntW'(ElapsedW - 1);
          frm_q <= '0;
          if (total_zero) begin
            state_q <= S_OUT;
          end else begin
            state_q <= S_MOD;
          end
        end
        S_MOD: begin
          rem_q <= mod_rem;
          bit_q <= bit_q - BitCntW'(1);
          if (bit_q == '0) begin
            if (reduce_q) begin
              elapsed_q <= ElapsedW'(mod_rem);
            end
            state_q <= S_PICK;
          end
        end
        S_PICK: begin
          if (!looping_q && fin) begin
            frm_q   <= FrameW'(n_q - CountW'(1));
            state_q <= S_OUT;
          end else begin
            frm_q   <= reverse_q ? FrameW'(n_q - CountW'(1)) : '0;
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          if (reverse_q) begin
            if (rev_ok) begin
              rem_q <= rem_q - walk_d;
              frm_q <= frm_q - FrameW'(1);
            end else begin
              state_q <= S_OUT;
            end
          end else begin
            if (fwd_ok) begin
              rem_q <= rem_q - walk_d;
              frm_q <= frm_q + FrameW'(1);
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {2'b00, elapsed_q, done_q, fin, frm_q};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`include "frame_animation_timer_macros.svh"

  `FAT_ASSERT(a_walk_in_range, (state_q == S_WALK) |-> (CountW'(frm_q) < n_q), "walk index")
  `FAT_ASSERT(a_rem_below_total, (state_q == S_PICK) |-> (rem_q < total_q), "remainder")
  `FAT_ASSERT(a_stop_no_done, (state_q == S_OUT && func_q == FUNC_STOP) |-> !done_q, "stop")
  `FAT_ASSERT(a_load_no_done, (state_q == S_OUT && func_q == FUNC_LOAD) |-> !done_q, "load")

endmodule
